@@ rtl/isc_pkg.sv @@
// shared types and codes of the binary sparse coder
// state machine encoding, command codes and register indexes; no dependencies
package isc_pkg;

	// command codes
	localparam logic [2:0] CMD_WR_WEIGHT = 3'd0;
	localparam logic [2:0] CMD_WR_INPUT  = 3'd1;
	localparam logic [2:0] CMD_WR_ACT    = 3'd2;
	localparam logic [2:0] CMD_ACTIVATE  = 3'd3;
	localparam logic [2:0] CMD_LEARN     = 3'd4;
	localparam logic [2:0] CMD_RD_RECON  = 3'd5;
	localparam logic [2:0] CMD_RD_WEIGHT = 3'd6;

	// configuration register indexes
	localparam logic [2:0] REG_VISIBLE = 3'd0;
	localparam logic [2:0] REG_HIDDEN  = 3'd1;
	localparam logic [2:0] REG_SWEEPS  = 3'd2;
	localparam logic [2:0] REG_STEP    = 3'd3;
	localparam logic [2:0] REG_SHRINK  = 3'd4;
	localparam logic [2:0] REG_LRATE   = 3'd5;

	// result kinds
	localparam logic KIND_CODE = 1'b0;
	localparam logic KIND_READ = 1'b1;

	typedef enum logic [25:0] {
		S_IDLE     = 26'h0000001,
		S_CLEAR    = 26'h0000002,
		S_RB_ELEM  = 26'h0000004,
		S_RB_RD    = 26'h0000008,
		S_RB_MUL   = 26'h0000010,
		S_RB_ACC   = 26'h0000020,
		S_RB_WR    = 26'h0000040,
		S_RB_END   = 26'h0000080,
		S_SW_BEGIN = 26'h0000100,
		S_SW_RD    = 26'h0000200,
		S_SW_MUL   = 26'h0000400,
		S_SW_ACC   = 26'h0000800,
		S_SW_Q     = 26'h0001000,
		S_SW_STEP  = 26'h0002000,
		S_SW_UPD   = 26'h0004000,
		S_BN_CHK   = 26'h0008000,
		S_BN_RD    = 26'h0010000,
		S_BN_WR    = 26'h0020000,
		S_LN_H     = 26'h0040000,
		S_LN_V     = 26'h0080000,
		S_LN_RD    = 26'h0100000,
		S_LN_MUL   = 26'h0200000,
		S_LN_MUL2  = 26'h0400000,
		S_LN_WR    = 26'h0800000,
		S_RD_WAIT  = 26'h1000000,
		S_OUT      = 26'h2000000
	} state_t;

endpackage

@@ rtl/isc_ram.sv @@
// generic single write port memory with registered read
// no dependencies
module isc_ram #(
	parameter int WIDTH = 16,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

@@ rtl/ista_binary_sparse_coder.sv @@
// top level of the binary sparse coder: sequencer, shared multiply-accumulate unit
// depends on isc_pkg and isc_ram
//
// Binary sparse coder running soft-threshold iterations in signed fixed point with
// 12 fraction bits. Commands on the input channel load weights, the input vector and
// initial activations, start an activation, apply one learning step, or read back a
// reconstruction value or a weight. Writes and learn give no result beat; activate
// returns the hidden code mask (kind 0), reads return the value (kind 1). All the
// arithmetic goes through one signed multiplier and one 64-bit saturating accumulator
// under a one-hot sequencer, and the block takes no new beat until the current command
// is done and its result sits in the output register. A multiply-accumulate steps through
// the memory read, multiply and accumulate states. An activate runs sweep_count+2
// reconstructions and sweep_count sweeps. After reset a clearing pass over
// max(VISIBLE_MAX, HIDDEN_MAX) addresses zeroes the reconstruction and activation
// memories; the input channel is stalled during it, configuration writes are taken.
// Configuration writes are expected only while the block is idle.
module ista_binary_sparse_coder
	import isc_pkg::*;
#(
	parameter int VISIBLE_MAX = 64,
	parameter int HIDDEN_MAX  = 64,
	parameter int VALUE_BITS  = 16
) (
	input  logic               clk,
	input  logic               arst_n,
	// configuration write channel
	input  logic               cfg_valid,
	output logic               cfg_ready,
	input  logic [2:0]         cfg_index,
	input  logic [15:0]        cfg_data,
	// command channel
	input  logic               in_valid,
	output logic               in_stall,
	input  logic [2:0]         cmd,
	input  logic [5:0]         hidden_index,
	input  logic [5:0]         visible_index,
	input  logic signed [15:0] value,
	// result channel
	output logic               out_valid,
	input  logic               out_stall,
	output logic               kind,
	output logic [63:0]        code,
	output logic signed [15:0] read_value
);

	localparam int VB    = VALUE_BITS;
	localparam int VW    = $clog2(VISIBLE_MAX);
	localparam int HW    = $clog2(HIDDEN_MAX);
	localparam int CVW   = $clog2(VISIBLE_MAX + 1);
	localparam int CHW   = $clog2(HIDDEN_MAX + 1);
	localparam int CLR_N = (VISIBLE_MAX > HIDDEN_MAX) ? VISIBLE_MAX : HIDDEN_MAX;
	localparam int CLW   = $clog2(CLR_N);
	localparam int MW    = (VB > 17) ? VB : 17;     // multiplier operand width
	localparam int PW    = 2 * MW;                  // product width
	localparam int AW    = 66;                      // wide working width

	localparam logic signed [AW-1:0] VMAX = (66'sd1 <<< (VALUE_BITS - 1)) - 66'sd1;
	localparam logic signed [AW-1:0] VMIN = -VMAX - 66'sd1;
	localparam logic signed [AW-1:0] ALIM = 66'sd1 <<< 62;
	localparam logic signed [AW-1:0] HALF = 66'sd2048;
	localparam logic signed [VB-1:0] ONE  = (VALUE_BITS > 13) ? VB'(4096) : VB'(VMAX);

	// saturate to the stored value range
	function automatic logic signed [VB-1:0] sat_v(input logic signed [AW-1:0] x);
		logic signed [AW-1:0] y;
		begin
			y = x;
			if (x > VMAX) y = VMAX;
			if (x < VMIN) y = VMIN;
			return VB'(y);
		end
	endfunction

	// round half up from 24 to 12 fraction bits, then saturate
	function automatic logic signed [VB-1:0] qnt(input logic signed [AW-1:0] x);
		logic signed [AW-1:0] y;
		begin
			y = x + HALF;
			return sat_v(y >>> 12);
		end
	endfunction

	state_t state_q;

	// configuration registers
	logic [6:0]  visible_count_q;
	logic [6:0]  hidden_count_q;
	logic [7:0]  sweep_count_q;
	logic [15:0] step_q;
	logic [15:0] shrink_q;
	logic [15:0] lrate_q;

	// sequencer state
	logic [CVW-1:0] v_q;
	logic [CHW-1:0] h_q;
	logic [CLW-1:0] clr_q;
	logic [7:0]     sw_left_q;
	logic           final_q;
	logic           rd_ok_q;
	logic           rd_weight_q;
	logic [63:0]    code_q;

	// datapath registers
	logic signed [63:0]   acc_q;
	logic signed [PW-1:0] prod_q;
	logic signed [VB-1:0] s_q;

	// output register
	logic               out_valid_q;
	logic               kind_q;
	logic [63:0]        out_code_q;
	logic signed [15:0] read_value_q;

	// memory ports
	logic                 w_we, in_we, rc_we, act_we;
	logic [HW+VW-1:0]     w_waddr, w_raddr;
	logic [VW-1:0]        in_waddr, rc_waddr, v_raddr;
	logic [HW-1:0]        act_waddr, act_raddr;
	logic signed [VB-1:0] w_wdata, in_wdata, rc_wdata, act_wdata;
	logic signed [VB-1:0] w_rd, in_rd, rc_rd, act_rd;

	isc_ram #(.WIDTH(VB), .DEPTH(2 ** (HW + VW))) u_weight_ram (
		.clk(clk), .we(w_we), .waddr(w_waddr), .wdata(w_wdata),
		.raddr(w_raddr), .rdata(w_rd)
	);

	isc_ram #(.WIDTH(VB), .DEPTH(VISIBLE_MAX)) u_input_ram (
		.clk(clk), .we(in_we), .waddr(in_waddr), .wdata(in_wdata),
		.raddr(v_raddr), .rdata(in_rd)
	);

	isc_ram #(.WIDTH(VB), .DEPTH(VISIBLE_MAX)) u_recon_ram (
		.clk(clk), .we(rc_we), .waddr(rc_waddr), .wdata(rc_wdata),
		.raddr(v_raddr), .rdata(rc_rd)
	);

	isc_ram #(.WIDTH(VB), .DEPTH(HIDDEN_MAX)) u_act_ram (
		.clk(clk), .we(act_we), .waddr(act_waddr), .wdata(act_wdata),
		.raddr(act_raddr), .rdata(act_rd)
	);

	// handshakes
	logic in_accept;
	logic out_take;
	assign cfg_ready = 1'b1;
	assign in_stall  = (state_q != S_IDLE);
	assign in_accept = in_valid && (state_q == S_IDLE);
	assign out_take  = out_valid_q && !out_stall;

	// index checks and counts in use
	logic           hok, vok;
	logic [CVW-1:0] nv;
	logic [CHW-1:0] nh;
	logic [CVW-1:0] v_nx;
	logic [CHW-1:0] h_nx;
	assign hok  = 32'(hidden_index) < HIDDEN_MAX;
	assign vok  = 32'(visible_index) < VISIBLE_MAX;
	assign nv   = ({25'd0, visible_count_q} > 32'(VISIBLE_MAX)) ? CVW'(VISIBLE_MAX)
	                                                             : CVW'(visible_count_q);
	assign nh   = ({25'd0, hidden_count_q} > 32'(HIDDEN_MAX)) ? CHW'(HIDDEN_MAX)
	                                                           : CHW'(hidden_count_q);
	assign v_nx = v_q + CVW'(1);
	assign h_nx = h_q + CHW'(1);

	// incoming value, sign-extended and saturated to the stored range
	logic signed [VB-1:0] val_in;
	assign val_in = sat_v(AW'(value));

	// read addresses follow the loop counters
	assign w_raddr   = {h_q[HW-1:0], v_q[VW-1:0]};
	assign v_raddr   = v_q[VW-1:0];
	assign act_raddr = h_q[HW-1:0];

	// residual of the current element
	logic signed [VB-1:0] resid;
	assign resid = sat_v(AW'(in_rd) - AW'(rc_rd));

	// product scaled back to 12 fraction bits
	logic signed [VB-1:0] prod_qnt;
	assign prod_qnt = qnt(AW'(prod_q));

	// shared multiplier
	logic signed [MW-1:0] op_a, op_b;
	logic signed [PW-1:0] mul;
	always_comb begin
		op_a = '0;
		op_b = '0;
		unique case (state_q)
			S_RB_MUL: begin
				op_a = MW'(w_rd);
				op_b = MW'(act_rd);
			end
			S_SW_MUL: begin
				op_a = MW'(resid);
				op_b = MW'(w_rd);
			end
			S_SW_STEP: begin
				op_a = MW'($signed({1'b0, step_q}));
				op_b = MW'(s_q);
			end
			S_LN_MUL: begin
				op_a = MW'(act_rd);
				op_b = MW'(resid);
			end
			S_LN_MUL2: begin
				op_a = MW'($signed({1'b0, lrate_q}));
				op_b = MW'(prod_qnt);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end
	assign mul = op_a * op_b;

	// saturating accumulate
	logic signed [AW-1:0] acc_sum;
	logic signed [63:0]   acc_nx;
	always_comb begin
		acc_sum = AW'(acc_q) + AW'(prod_q);
		if (acc_sum > ALIM) begin
			acc_nx = 64'(ALIM);
		end else if (acc_sum < -ALIM) begin
			acc_nx = 64'(-ALIM);
		end else begin
			acc_nx = 64'(acc_sum);
		end
	end

	// activation update with soft threshold
	logic signed [VB-1:0] act_upd;
	logic signed [AW-1:0] a_w, r_w;
	always_comb begin
		a_w = AW'(sat_v(AW'(act_rd) + AW'(prod_qnt)));
		if (a_w > 0) begin
			r_w = a_w - AW'($signed({1'b0, shrink_q}));
		end else begin
			r_w = a_w + AW'($signed({1'b0, shrink_q}));
		end
		if ((a_w > 0) != (r_w > 0)) begin
			act_upd = '0;
		end else begin
			act_upd = sat_v(r_w);
		end
	end

	// memory writes
	always_comb begin
		w_we      = 1'b0;
		w_waddr   = {hidden_index[HW-1:0], VW'(visible_index)};
		w_wdata   = val_in;
		in_we     = in_accept && (cmd == CMD_WR_INPUT) && vok;
		in_waddr  = VW'(visible_index);
		in_wdata  = val_in;
		rc_we     = 1'b0;
		rc_waddr  = v_q[VW-1:0];
		rc_wdata  = qnt(AW'(acc_q));
		act_we    = 1'b0;
		act_waddr = h_q[HW-1:0];
		act_wdata = act_upd;
		unique case (state_q)
			S_IDLE: begin
				w_we      = in_accept && (cmd == CMD_WR_WEIGHT) && hok && vok;
				act_we    = in_accept && (cmd == CMD_WR_ACT) && hok;
				act_waddr = hidden_index[HW-1:0];
				act_wdata = val_in;
			end
			S_CLEAR: begin
				rc_we     = 32'(clr_q) < VISIBLE_MAX;
				rc_waddr  = clr_q[VW-1:0];
				rc_wdata  = '0;
				act_we    = 32'(clr_q) < HIDDEN_MAX;
				act_waddr = clr_q[HW-1:0];
				act_wdata = '0;
			end
			S_RB_WR: begin
				rc_we = 1'b1;
			end
			S_SW_UPD: begin
				act_we = 1'b1;
			end
			S_BN_WR: begin
				act_we    = (act_rd != '0);
				act_wdata = ONE;
			end
			S_LN_WR: begin
				w_we    = 1'b1;
				w_waddr = {h_q[HW-1:0], v_q[VW-1:0]};
				w_wdata = sat_v(AW'(w_rd) + AW'(prod_qnt));
			end
			default: begin
				w_we = 1'b0;
			end
		endcase
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			visible_count_q <= 7'd64;
			hidden_count_q  <= 7'd64;
			sweep_count_q   <= 8'd10;
			step_q          <= 16'd410;
			shrink_q        <= 16'd41;
			lrate_q         <= 16'd41;
		end else if (cfg_valid && cfg_ready) begin
			unique case (cfg_index)
				REG_VISIBLE: visible_count_q <= cfg_data[6:0];
				REG_HIDDEN:  hidden_count_q  <= cfg_data[6:0];
				REG_SWEEPS:  sweep_count_q   <= cfg_data[7:0];
				REG_STEP:    step_q          <= cfg_data;
				REG_SHRINK:  shrink_q        <= cfg_data;
				REG_LRATE:   lrate_q         <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// datapath registers, no reset needed
	always_ff @(posedge clk) begin
		prod_q <= mul;
		unique case (state_q)
			S_RB_ELEM, S_SW_BEGIN: acc_q <= '0;
			S_RB_ACC, S_SW_ACC:    acc_q <= acc_nx;
			default: begin
			end
		endcase
		if (state_q == S_SW_Q) begin
			s_q <= qnt(AW'(acc_q));
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			v_q          <= '0;
			h_q          <= '0;
			clr_q        <= '0;
			sw_left_q    <= '0;
			final_q      <= 1'b0;
			rd_ok_q      <= 1'b0;
			rd_weight_q  <= 1'b0;
			code_q       <= '0;
			out_valid_q  <= 1'b0;
			kind_q       <= KIND_CODE;
			out_code_q   <= '0;
			read_value_q <= '0;
		end else begin
			// the result hand-off below reloads the register itself
			if (out_take && (state_q != S_OUT)) begin
				out_valid_q <= 1'b0;
			end
			unique case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + CLW'(1);
					if (32'(clr_q) == CLR_N - 1) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (in_accept) begin
						unique case (cmd)
							CMD_ACTIVATE: begin
								v_q       <= '0;
								code_q    <= '0;
								sw_left_q <= sweep_count_q;
								final_q   <= 1'b0;
								state_q   <= S_RB_ELEM;
							end
							CMD_LEARN: begin
								h_q     <= '0;
								state_q <= S_LN_H;
							end
							CMD_RD_RECON: begin
								h_q         <= CHW'(hidden_index);
								v_q         <= CVW'(visible_index);
								rd_ok_q     <= vok;
								rd_weight_q <= 1'b0;
								state_q     <= S_RD_WAIT;
							end
							CMD_RD_WEIGHT: begin
								h_q         <= CHW'(hidden_index);
								v_q         <= CVW'(visible_index);
								rd_ok_q     <= hok && vok;
								rd_weight_q <= 1'b1;
								state_q     <= S_RD_WAIT;
							end
							default: begin
								state_q <= S_IDLE;
							end
						endcase
					end
				end
				// reconstruction, element by element
				S_RB_ELEM: begin
					h_q <= '0;
					if (v_q == nv) begin
						state_q <= S_RB_END;
					end else if (nh == '0) begin
						state_q <= S_RB_WR;
					end else begin
						state_q <= S_RB_RD;
					end
				end
				S_RB_RD:  state_q <= S_RB_MUL;
				S_RB_MUL: state_q <= S_RB_ACC;
				S_RB_ACC: begin
					h_q     <= h_nx;
					state_q <= (h_nx == nh) ? S_RB_WR : S_RB_RD;
				end
				S_RB_WR: begin
					v_q     <= v_nx;
					state_q <= S_RB_ELEM;
				end
				S_RB_END: begin
					h_q <= '0;
					if (final_q) begin
						state_q <= S_OUT;
					end else if (sw_left_q != '0) begin
						sw_left_q <= sw_left_q - 8'd1;
						state_q   <= S_SW_BEGIN;
					end else begin
						state_q <= S_BN_CHK;
					end
				end
				// one sweep, unit by unit
				S_SW_BEGIN: begin
					v_q <= '0;
					if (h_q == nh) begin
						state_q <= S_RB_ELEM;
					end else if (nv == '0) begin
						state_q <= S_SW_Q;
					end else begin
						state_q <= S_SW_RD;
					end
				end
				S_SW_RD:  state_q <= S_SW_MUL;
				S_SW_MUL: state_q <= S_SW_ACC;
				S_SW_ACC: begin
					v_q     <= v_nx;
					state_q <= (v_nx == nv) ? S_SW_Q : S_SW_RD;
				end
				S_SW_Q:    state_q <= S_SW_STEP;
				S_SW_STEP: state_q <= S_SW_UPD;
				S_SW_UPD: begin
					h_q     <= h_nx;
					state_q <= S_SW_BEGIN;
				end
				// binarize
				S_BN_CHK: begin
					if (h_q == nh) begin
						v_q     <= '0;
						final_q <= 1'b1;
						state_q <= S_RB_ELEM;
					end else begin
						state_q <= S_BN_RD;
					end
				end
				S_BN_RD: state_q <= S_BN_WR;
				S_BN_WR: begin
					if (act_rd != '0) begin
						code_q[h_q[HW-1:0]] <= 1'b1;
					end
					h_q     <= h_nx;
					state_q <= S_BN_CHK;
				end
				// learning step, row by row
				S_LN_H: begin
					v_q     <= '0;
					state_q <= (h_q == nh) ? S_IDLE : S_LN_V;
				end
				S_LN_V: begin
					if (v_q == nv) begin
						h_q     <= h_nx;
						state_q <= S_LN_H;
					end else begin
						state_q <= S_LN_RD;
					end
				end
				S_LN_RD:   state_q <= S_LN_MUL;
				S_LN_MUL:  state_q <= S_LN_MUL2;
				S_LN_MUL2: state_q <= S_LN_WR;
				S_LN_WR: begin
					v_q     <= v_nx;
					state_q <= S_LN_V;
				end
				S_RD_WAIT: begin
					final_q <= 1'b0;
					state_q <= S_OUT;
				end
				// hand the result to the output register once it is free
				S_OUT: begin
					if (!out_valid_q || !out_stall) begin
						out_valid_q <= 1'b1;
						if (rd_weight_q || !final_q) begin
							kind_q     <= KIND_READ;
							out_code_q <= '0;
							if (!rd_ok_q) begin
								read_value_q <= '0;
							end else if (rd_weight_q) begin
								read_value_q <= 16'(w_rd);
							end else begin
								read_value_q <= 16'(rc_rd);
							end
						end else begin
							kind_q       <= KIND_CODE;
							out_code_q   <= code_q;
							read_value_q <= '0;
						end
						rd_weight_q <= 1'b0;
						state_q     <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign out_valid  = out_valid_q;
	assign kind       = kind_q;
	assign code       = out_code_q;
	assign read_value = read_value_q;

endmodule
